// ===== rtl/shs_pkg.sv =====
package shs_pkg;

  typedef logic [0:7][31:0] words_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] digest_byte;
    logic       digest_last;
  } out_item_t;

  typedef struct packed {
    logic       shift_en;
    logic [7:0] shift_byte;
    logic       start;
    logic       init;
  } ctrl_t;

  localparam words_t HashInit = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PadMarker = 8'h80;
  localparam logic [63:0] BlockBits = 64'd512;

endpackage

// ===== rtl/shs_core.sv =====
module shs_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  shs_pkg::ctrl_t  ctrl_i,
  output logic            done_o,
  output shs_pkg::words_t chain_o
);

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  // 16-word window: bytes shift in at the bottom, w[0] sits at the top
  logic [511:0] win_q, win_d;
  shs_pkg::words_t v_q, v_d;
  shs_pkg::words_t chain_q, chain_d;
  logic [5:0] rnd_q, rnd_d;
  logic busy_q, busy_d;
  logic add_q, add_d;

  logic [31:0] w0, w1, w9, w14, w_new;
  logic [31:0] s0, s1, big0, big1, choose, major, t1, t2;

  always_comb begin
    w0  = win_q[511:480];
    w1  = win_q[479:448];
    w9  = win_q[223:192];
    w14 = win_q[63:32];
    s0  = ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3);
    s1  = ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10);
    w_new = s1 + s0 + w9 + w0;

    big1   = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
    choose = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    big0   = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
    major  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1 = v_q[7] + big1 + choose + shs_pkg::RoundK[rnd_q] + w0;
    t2 = big0 + major;

    win_d   = win_q;
    v_d     = v_q;
    chain_d = chain_q;
    rnd_d   = rnd_q;
    busy_d  = busy_q;
    add_d   = 1'b0;

    if (ctrl_i.shift_en) begin
      win_d = {win_q[503:0], ctrl_i.shift_byte};
    end else if (busy_q) begin
      win_d = {win_q[479:0], w_new};
    end

    if (ctrl_i.start) begin
      v_d    = chain_q;
      rnd_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      v_d   = {t1 + t2, v_q[0], v_q[1], v_q[2], v_q[3] + t1, v_q[4], v_q[5], v_q[6]};
      rnd_d = rnd_q + 6'd1;
      if (rnd_q == 6'd63) begin
        busy_d = 1'b0;
        add_d  = 1'b1;
      end
    end

    if (ctrl_i.init) begin
      chain_d = shs_pkg::HashInit;
    end else if (add_q) begin
      for (int i = 0; i < 8; i++) begin
        chain_d[i] = chain_q[i] + v_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= shs_pkg::HashInit;
      rnd_q   <= '0;
      busy_q  <= 1'b0;
      add_q   <= 1'b0;
    end else begin
      chain_q <= chain_d;
      rnd_q   <= rnd_d;
      busy_q  <= busy_d;
      add_q   <= add_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    v_q   <= v_d;
  end

  assign done_o  = add_q;
  assign chain_o = chain_q;

endmodule

// ===== rtl/sha256_stream_hasher_unit.sv =====
// SHA-256 hasher fed one message byte per item.
// Input channel (in_valid_i/in_ready_o, in_item_i): each item may carry a
// byte (byte_present) and may close the message (end_of_message). An end
// item with no byte closes whatever is pending, so an empty message works.
// Output channel (out_valid_o/out_ready_i, out_item_o): 32 digest bytes,
// word 0 first, most significant byte first, digest_last on the 32nd.
// Byte items are taken back to back while idle. Every 64th byte starts a
// compression of 64 rounds and then the chaining add, during which
// in_ready_o is low; the rounds run one after another in the single round
// unit. An end item pads one byte per cycle up to the block boundary (over
// two blocks when an extra block is needed), compresses, latches the digest
// in the S_DIG state, then holds it in an output register and shifts out
// one byte per accepted item. A stalled receiver simply holds the block in
// the output state; no input is taken until the last digest byte is accepted.
// Reset sets the chaining words to the initial hash values and clears the
// byte and bit counts; the hasher returns to that state after each digest.
module sha256_stream_hasher_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  shs_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output shs_pkg::out_item_t out_item_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_COMP = 3'd2;
  localparam logic [2:0] S_DIG  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [63:0] bits_q, bits_d;
  logic [63:0] len_q, len_d;
  logic fin_q, fin_d;
  logic marker_q, marker_d;
  logic final_q, final_d;
  logic [4:0] out_cnt_q, out_cnt_d;
  logic [255:0] dig_q, dig_d;

  shs_pkg::ctrl_t ctrl;
  shs_pkg::words_t chain;
  logic core_done;

  shs_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .done_o  (core_done),
    .chain_o (chain)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_item_o.digest_byte = dig_q[255:248];
  assign out_item_o.digest_last = (out_cnt_q == 5'd31);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    bits_d    = bits_q;
    len_d     = len_q;
    fin_d     = fin_q;
    marker_d  = marker_q;
    final_d   = final_q;
    out_cnt_d = out_cnt_q;
    dig_d     = dig_q;
    ctrl      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          fin_d = in_item_i.end_of_message;
          if (in_item_i.byte_present) begin
            ctrl.shift_en   = 1'b1;
            ctrl.shift_byte = in_item_i.data_byte;
            cnt_d = cnt_q + 6'd1;
            if (cnt_q == 6'd63) begin
              bits_d     = bits_q + shs_pkg::BlockBits;
              ctrl.start = 1'b1;
              state_d    = S_COMP;
            end else if (in_item_i.end_of_message) begin
              state_d = S_PAD;
            end
          end else if (in_item_i.end_of_message) begin
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        ctrl.shift_en = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (!marker_q) begin
          ctrl.shift_byte = shs_pkg::PadMarker;
          marker_d = 1'b1;
          final_d  = (cnt_q < 6'd56);
          len_d    = bits_q + {55'd0, cnt_q, 3'd0};
        end else if (final_q && cnt_q >= 6'd56) begin
          ctrl.shift_byte = len_q[63:56];
          len_d = {len_q[55:0], 8'd0};
        end else begin
          ctrl.shift_byte = 8'd0;
        end
        if (cnt_q == 6'd63) begin
          ctrl.start = 1'b1;
          state_d    = S_COMP;
        end
      end
      S_COMP: begin
        if (core_done) begin
          if (!fin_q) begin
            state_d = S_IDLE;
          end else if (marker_q && final_q) begin
            state_d = S_DIG;
          end else begin
            final_d = marker_q;
            state_d = S_PAD;
          end
        end
      end
      S_DIG: begin
        dig_d     = chain;
        ctrl.init = 1'b1;
        bits_d    = '0;
        cnt_d     = '0;
        fin_d     = 1'b0;
        marker_d  = 1'b0;
        final_d   = 1'b0;
        out_cnt_d = '0;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          dig_d     = {dig_q[247:0], 8'd0};
          out_cnt_d = out_cnt_q + 5'd1;
          if (out_cnt_q == 5'd31) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      bits_q    <= '0;
      fin_q     <= 1'b0;
      marker_q  <= 1'b0;
      final_q   <= 1'b0;
      out_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      bits_q    <= bits_d;
      fin_q     <= fin_d;
      marker_q  <= marker_d;
      final_q   <= final_d;
      out_cnt_q <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    dig_q <= dig_d;
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  shs_pkg::in_item_t  in_item_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  shs_pkg::out_item_t out_item_o;

  sha256_stream_hasher_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  shs_pkg::in_item_t  stim_q[$];
  shs_pkg::out_item_t digest_q[$];
  shs_pkg::out_item_t want;

  logic [31:0] hash_chain[8];
  logic [7:0]  blk_buf[64];
  int          pend_cnt;
  logic [63:0] bits_done;

  int          in_count = 0;
  int          err_cnt = 0;
  int          msgs_done = 0;
  int          blocks_done = 0;
  int          bytes_checked = 0;
  int          max_len = 0;
  int          cur_len = 0;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void reset_hash();
    for (int k = 0; k < 8; k++) hash_chain[k] = shs_pkg::HashInit[k];
    pend_cnt  = 0;
    bits_done = '0;
  endfunction

  function automatic void compress_blk();
    logic [31:0] w[64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int r = 0; r < 16; r++)
      w[r] = {blk_buf[4*r], blk_buf[4*r+1], blk_buf[4*r+2], blk_buf[4*r+3]};
    for (int r = 16; r < 64; r++) begin
      s0 = ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3);
      s1 = ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10);
      w[r] = s1 + s0 + w[r-7] + w[r-16];
    end
    a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
    e = hash_chain[4]; f = hash_chain[5]; g = hash_chain[6]; h = hash_chain[7];
    for (int r = 0; r < 64; r++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
           + shs_pkg::RoundK[r] + w[r];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c; hash_chain[3] += d;
    hash_chain[4] += e; hash_chain[5] += f; hash_chain[6] += g; hash_chain[7] += h;
    blocks_done++;
  endfunction

  function automatic void predict_digest(input shs_pkg::in_item_t it);
    logic [63:0]        total;
    shs_pkg::out_item_t o;
    int                 i;
    if (it.byte_present) begin
      blk_buf[pend_cnt] = it.data_byte;
      pend_cnt++;
      if (pend_cnt == 64) begin
        compress_blk();
        bits_done += shs_pkg::BlockBits;
        pend_cnt = 0;
      end
    end
    if (!it.end_of_message) return;
    total = bits_done + 64'(pend_cnt) * 8;
    i = pend_cnt;
    blk_buf[i] = shs_pkg::PadMarker;
    i++;
    if (i > 56) begin
      while (i < 64) begin
        blk_buf[i] = 8'h00;
        i++;
      end
      compress_blk();
      i = 0;
    end
    while (i < 56) begin
      blk_buf[i] = 8'h00;
      i++;
    end
    for (int k = 0; k < 8; k++) blk_buf[63-k] = total[8*k +: 8];
    compress_blk();
    for (int k = 0; k < 32; k++) begin
      o.digest_byte = hash_chain[k/4][24 - 8*(k%4) +: 8];
      o.digest_last = (k == 31);
      digest_q.push_back(o);
    end
    msgs_done++;
    reset_hash();
  endfunction

  // no back-pressure or gaps while in_count is inside this window
  function automatic bit idle_now();
    if (in_count >= 40 && in_count < 120) return 1'b0;
    return $urandom_range(0, 99) < 32;
  endfunction

  function automatic shs_pkg::in_item_t mk_item(input logic [7:0] d, input bit p,
                                                input bit f);
    shs_pkg::in_item_t it;
    it.data_byte      = d;
    it.byte_present   = p;
    it.end_of_message = f;
    return it;
  endfunction

  // returns number of items pushed
  function automatic int add_message(input int len, input bit end_on_byte);
    int n;
    n = 0;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        stim_q.push_back(mk_item(8'($urandom), 1'b0, 1'b0));
        n++;
      end
      stim_q.push_back(mk_item(8'($urandom), 1'b1, end_on_byte && (k == len - 1)));
      n++;
    end
    if (len == 0 || !end_on_byte) begin
      stim_q.push_back(mk_item(8'($urandom), 1'b0, 1'b1));
      n++;
    end
    return n;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_digest(in_item_i);
        in_count <= in_count + 1;
        if (in_item_i.byte_present) cur_len++;
        if (in_item_i.end_of_message) begin
          if (cur_len > max_len) max_len = cur_len;
          cur_len = 0;
        end
      end
      if (!in_valid_i || in_ready_o) begin
        if (stim_q.size() != 0 && !idle_now()) begin
          in_valid_i <= 1'b1;
          in_item_i  <= stim_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest item, actual byte=%02h last=%0b",
                   $time, out_item_o.digest_byte, out_item_o.digest_last);
          err_cnt++;
        end else begin
          want = digest_q.pop_front();
          bytes_checked++;
          if (out_item_o.digest_byte !== want.digest_byte) begin
            $display("%0t: digest_byte expected %02h actual %02h",
                     $time, want.digest_byte, out_item_o.digest_byte);
            err_cnt++;
          end
          if (out_item_o.digest_last !== want.digest_last) begin
            $display("%0t: digest_last expected %0b actual %0b",
                     $time, want.digest_last, out_item_o.digest_last);
            err_cnt++;
          end
        end
      end
      out_ready_i <= !idle_now();
    end
  end

  initial begin
    int n;
    int lens[3];
    reset_hash();
    for (int k = 0; k < 64; k++) blk_buf[k] = 8'h00;

    // directed: ignored item, empty message, single-byte end items, short messages
    stim_q.push_back(mk_item(8'hff, 1'b0, 1'b0));
    stim_q.push_back(mk_item(8'h00, 1'b0, 1'b1));
    stim_q.push_back(mk_item(8'h00, 1'b1, 1'b1));
    stim_q.push_back(mk_item(8'hff, 1'b1, 1'b1));
    stim_q.push_back(mk_item(8'hff, 1'b1, 1'b0));
    stim_q.push_back(mk_item(8'h00, 1'b1, 1'b0));
    stim_q.push_back(mk_item(8'h80, 1'b1, 1'b0));
    stim_q.push_back(mk_item(8'h55, 1'b0, 1'b0));
    stim_q.push_back(mk_item(8'h7f, 1'b0, 1'b1));
    stim_q.push_back(mk_item(8'h61, 1'b1, 1'b0));
    stim_q.push_back(mk_item(8'h62, 1'b1, 1'b0));
    stim_q.push_back(mk_item(8'h63, 1'b1, 1'b1));
    stim_q.push_back(mk_item(8'h00, 1'b0, 1'b1));

    // padding boundaries: last fit, extra block, full block
    lens = '{55, 56, 64};
    n = stim_q.size();
    for (int k = 0; k < 3; k++) n += add_message(lens[k], 1'($urandom_range(0, 1)));
    while (n < 180) begin
      if ($urandom_range(0, 3) == 0)
        n += add_message($urandom_range(0, 70), 1'($urandom_range(0, 1)));
      else
        n += add_message($urandom_range(0, 8), 1'($urandom_range(0, 1)));
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() != 0 || in_valid_i || digest_q.size() != 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    $display("hashed %0d messages (longest %0d bytes), %0d compressions predicted",
             msgs_done, max_len, blocks_done);
    $display("%0d digest bytes compared, %0d left unmatched", bytes_checked,
             digest_q.size());
    if (err_cnt == 0 && digest_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout at %0t", $time);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sha256_stream_hasher_unit.f =====
rtl/shs_pkg.sv
rtl/shs_core.sv
rtl/sha256_stream_hasher_unit.sv
tb/sv/tb_top.sv
